[rtl/assert_macros.svh]
// Assertion helpers for the odometry block.
// ODO_ASSERT_CLK takes the clock and reset by name; ODO_ASSERT uses clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ODO_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`define ODO_ASSERT(lbl, prop, msg) `ODO_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

[rtl/odo_pkg.sv]
// ----------------------------------------------------------------------------
// odo_pkg
// Shared widths, constants, CORDIC angle table and control types for the
// wheel odometry pose update core.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POSITION_BITS_DEF = 48;

  localparam int WHEEL_W = 32;          // Q16.16 wheel distance
  localparam int DIFF_W  = WHEEL_W + 1; // wheel delta
  localparam int SUM_W   = WHEEL_W + 2; // sum of two deltas
  localparam int ANG_W   = 16;          // binary heading
  localparam int TS_W    = 16;          // Q4.12 time step
  localparam int OUT_W   = 48;          // Q32.16 position port

  localparam int TRIG_W  = 32;          // Q2.30 sin / cos
  localparam int DIG_W   = 16;          // multiplier digit of sin / cos
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = DIG_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 68;
  localparam int DELTA_W = 42;          // position increment

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int XY_W         = 34;
  localparam int Z_W          = 34;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

  typedef struct packed {
    logic en;     // update accumulator
    logic clear;  // start a new product
    logic hi;     // upper digit, weight 2^16
  } mac_ctl_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic signed [TRIG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sh20000000;
      5'd1:    v = 32'sh12E4051E;
      5'd2:    v = 32'sh09FB385B;
      5'd3:    v = 32'sh051111D4;
      5'd4:    v = 32'sh028B0D43;
      5'd5:    v = 32'sh0145D7E1;
      5'd6:    v = 32'sh00A2F61E;
      5'd7:    v = 32'sh00517C55;
      5'd8:    v = 32'sh0028BE53;
      5'd9:    v = 32'sh00145F2F;
      5'd10:   v = 32'sh000A2F98;
      5'd11:   v = 32'sh000517CC;
      5'd12:   v = 32'sh00028BE6;
      5'd13:   v = 32'sh000145F3;
      5'd14:   v = 32'sh0000A2FA;
      5'd15:   v = 32'sh0000517D;
      5'd16:   v = 32'sh000028BE;
      5'd17:   v = 32'sh0000145F;
      5'd18:   v = 32'sh00000A30;
      5'd19:   v = 32'sh00000518;
      5'd20:   v = 32'sh0000028C;
      5'd21:   v = 32'sh00000146;
      5'd22:   v = 32'sh000000A3;
      5'd23:   v = 32'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/odo_cordic.sv]
// ----------------------------------------------------------------------------
// odo_cordic
// Rotation-mode CORDIC, one iteration per cycle. Produces Q2.30 sin and cos
// of a 16-bit binary angle, folded into the right half plane.
// ----------------------------------------------------------------------------
module odo_cordic #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [odo_pkg::ANG_W-1:0]              heading,
  output logic                                   done,
  output logic signed [odo_pkg::TRIG_W-1:0]      sin_out,
  output logic signed [odo_pkg::TRIG_W-1:0]      cos_out
);

  localparam int NSTEP = (CORDIC_STEPS > odo_pkg::ATAN_ENTRIES) ?
                         odo_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CNT_W = $clog2(NSTEP);

  logic                             busy_r;
  logic                             fin_r;
  logic                             done_r;
  logic                             neg_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic signed [odo_pkg::XY_W-1:0]  x_r;
  logic signed [odo_pkg::XY_W-1:0]  y_r;
  logic signed [odo_pkg::Z_W-1:0]   z_r;
  logic signed [odo_pkg::TRIG_W-1:0] sin_r;
  logic signed [odo_pkg::TRIG_W-1:0] cos_r;

  logic                             last_iter;
  logic signed [odo_pkg::XY_W-1:0]  x_sh;
  logic signed [odo_pkg::XY_W-1:0]  y_sh;
  logic signed [odo_pkg::Z_W-1:0]   atan_z;
  logic                             fold;
  logic [2*odo_pkg::ANG_W-1:0]      ang;
  logic [2*odo_pkg::ANG_W-1:0]      ang_fold;

  assign last_iter = busy_r && (cnt_r == CNT_W'(NSTEP - 1));
  assign x_sh      = x_r >>> cnt_r;
  assign y_sh      = y_r >>> cnt_r;
  assign atan_z    = odo_pkg::Z_W'(odo_pkg::atan_turn(odo_pkg::ATAN_IDX_W'(cnt_r)));

  // Angles in the left half plane: rotate by half a turn, negate results.
  assign ang      = {heading, {odo_pkg::ANG_W{1'b0}}};
  assign fold     = heading[odo_pkg::ANG_W-1] ^ heading[odo_pkg::ANG_W-2];
  assign ang_fold = fold ? {~ang[2*odo_pkg::ANG_W-1], ang[2*odo_pkg::ANG_W-2:0]} : ang;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= last_iter;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last_iter) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      neg_r <= fold;
      x_r   <= odo_pkg::XY_W'(odo_pkg::CORDIC_GAIN);
      y_r   <= '0;
      z_r   <= odo_pkg::Z_W'(signed'(ang_fold));
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (!z_r[odo_pkg::Z_W-1]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_z;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_z;
      end
    end
    if (fin_r) begin
      sin_r <= odo_pkg::TRIG_W'(neg_r ? -y_r : y_r);
      cos_r <= odo_pkg::TRIG_W'(neg_r ? -x_r : x_r);
    end
  end

  assign done    = done_r;
  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule

[rtl/odo_mac.sv]
// ----------------------------------------------------------------------------
// odo_mac
// Shared signed multiply-accumulate: a 35 x 17 bit product per cycle, added
// into a wide accumulator at weight 1 or 2^16. Wide products take two passes.
// ----------------------------------------------------------------------------
module odo_mac (
  input  logic                                  clk,
  input  odo_pkg::mac_ctl_t                     ctl,
  input  logic signed [odo_pkg::MUL_A_W-1:0]    op_a,
  input  logic signed [odo_pkg::MUL_B_W-1:0]    op_b,
  output logic signed [odo_pkg::ACC_W-1:0]      acc
);

  logic signed [odo_pkg::ACC_W-1:0]  acc_r;
  logic signed [odo_pkg::PROD_W-1:0] prod;
  logic signed [odo_pkg::ACC_W-1:0]  prod_ext;
  logic signed [odo_pkg::ACC_W-1:0]  addend;
  logic signed [odo_pkg::ACC_W-1:0]  base;

  assign prod     = op_a * op_b;
  assign prod_ext = odo_pkg::ACC_W'(prod);
  assign addend   = ctl.hi ? (prod_ext <<< odo_pkg::DIG_W) : prod_ext;
  assign base     = ctl.clear ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= base + addend;
    end
  end

  assign acc = acc_r;

endmodule

[rtl/wheel_odometry_pose_update_core.sv]
// ----------------------------------------------------------------------------
// wheel_odometry_pose_update_core
// Tracking-wheel odometry: wheel deltas rotated by the heading into a
// saturating global X/Y position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one sample: three wheel
//   distances, a binary heading and a time step. Output channel
//   (out_valid / out_stall) returns the updated X/Y position, one result
//   per sample. cfg_wr_en / cfg_wr_data set the mode; the user must write it
//   only while idle, and the block itself does not enforce this. A sample
//   runs the CORDIC for min(CORDIC_STEPS, 24) iterations, then the shared
//   multiplier (mode 0: four 2-digit products; mode 1: two 2-digit products,
//   then the two time-step products in a single pass each), then the
//   saturation state. No new sample is taken until the result of the last
//   one is transferred: in_stall stays high from the input transfer until
//   the result transfer. A stalled result holds its value. Reset clears the
//   mode, the kept wheel readings and the position to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wheel_odometry_pose_update_core #(
  parameter int CORDIC_STEPS  = odo_pkg::CORDIC_STEPS_DEF,
  parameter int POSITION_BITS = odo_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [odo_pkg::WHEEL_W-1:0]    in_left_wheel,
  input  logic signed [odo_pkg::WHEEL_W-1:0]    in_right_wheel,
  input  logic signed [odo_pkg::WHEEL_W-1:0]    in_tracking_wheel,
  input  logic [odo_pkg::ANG_W-1:0]             in_heading,
  input  logic [odo_pkg::TS_W-1:0]              in_time_step,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [odo_pkg::OUT_W-1:0]      out_x_position,
  output logic signed [odo_pkg::OUT_W-1:0]      out_y_position
);

  localparam int SW = ((POSITION_BITS > odo_pkg::DELTA_W) ?
                       POSITION_BITS : odo_pkg::DELTA_W) + 1;
  localparam int EW = (POSITION_BITS > odo_pkg::OUT_W) ? POSITION_BITS : odo_pkg::OUT_W;
  localparam logic signed [SW-1:0] POS_MAX = (SW'(1) <<< (POSITION_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);
  localparam logic signed [odo_pkg::ACC_W-1:0] RND30 = odo_pkg::ACC_W'(1) <<< 29;
  localparam logic signed [odo_pkg::ACC_W-1:0] RND12 = odo_pkg::ACC_W'(1) <<< 11;

  // Product schedule, indexed by op_cnt_r[3:1]; op_cnt_r[0] picks the pass.
  localparam logic [2:0] PR0_FS  = 3'd0;  // fwd * sin
  localparam logic [2:0] PR0_DC  = 3'd1;  // side * cos
  localparam logic [2:0] PR0_FC  = 3'd2;  // fwd * cos
  localparam logic [2:0] PR0_DS  = 3'd3;  // side * sin
  localparam logic [2:0] PR0_END = 3'd4;
  localparam logic [2:0] PR1_FS  = 3'd0;  // fwd * sin
  localparam logic [2:0] PR1_FC  = 3'd1;  // fwd * cos
  localparam logic [2:0] PR1_TS  = 3'd2;  // both rounded products * time step
  localparam logic [2:0] PR1_END = 3'd3;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CORDIC = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_SAT    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t                                state_r, state_nxt;
  logic                                  mode_r;
  logic [3:0]                            op_cnt_r;
  logic signed [odo_pkg::WHEEL_W-1:0]    last_left_r, last_right_r, last_track_r;
  logic signed [odo_pkg::DIFF_W-1:0]     fwd_r, dt_r;
  logic [odo_pkg::TS_W-1:0]              ts_r;
  logic signed [odo_pkg::MUL_A_W-1:0]    r_r, r_nxt;
  logic signed [odo_pkg::DELTA_W-1:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [POSITION_BITS-1:0]       x_acc_r, y_acc_r;

  logic                                  in_xfer;
  logic signed [odo_pkg::DIFF_W-1:0]     dl, dr, dt;
  logic signed [odo_pkg::SUM_W-1:0]      dsum;
  logic                                  cor_done;
  logic signed [odo_pkg::TRIG_W-1:0]     cor_sin, cor_cos;
  odo_pkg::mac_ctl_t                     mac_ctl;
  logic signed [odo_pkg::MUL_A_W-1:0]    mac_a;
  logic signed [odo_pkg::MUL_B_W-1:0]    mac_b;
  logic signed [odo_pkg::ACC_W-1:0]      mac_acc;
  logic signed [odo_pkg::ACC_W-1:0]      rq_full, r12_full;
  logic signed [odo_pkg::MUL_B_W-1:0]    s_dig, c_dig, ts_b;
  logic signed [odo_pkg::MUL_A_W-1:0]    fwd_a, dt_a;
  logic                                  half;
  logic [2:0]                            prod_idx;
  logic                                  mul_last;
  logic signed [EW-1:0]                  x_ext, y_ext;

  function automatic logic signed [POSITION_BITS-1:0] sat_add(
    input logic signed [POSITION_BITS-1:0]   acc,
    input logic signed [odo_pkg::DELTA_W-1:0] d
  );
    logic signed [SW-1:0] sum;
    sum = SW'(acc) + SW'(d);
    if (sum > POS_MAX) begin
      return POSITION_BITS'(POS_MAX);
    end else if (sum < POS_MIN) begin
      return POSITION_BITS'(POS_MIN);
    end
    return POSITION_BITS'(sum);
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);

  assign dl   = odo_pkg::DIFF_W'(in_left_wheel) - odo_pkg::DIFF_W'(last_left_r);
  assign dr   = odo_pkg::DIFF_W'(in_right_wheel) - odo_pkg::DIFF_W'(last_right_r);
  assign dt   = odo_pkg::DIFF_W'(in_tracking_wheel) - odo_pkg::DIFF_W'(last_track_r);
  assign dsum = odo_pkg::SUM_W'(dl) + odo_pkg::SUM_W'(dr);

  odo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer),
    .heading (in_heading),
    .done    (cor_done),
    .sin_out (cor_sin),
    .cos_out (cor_cos)
  );

  odo_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  // Round a Q2.30 product to Q16.16, and a Q4.12 time product to Q16.16.
  assign rq_full  = (mac_acc + RND30) >>> 30;
  assign r12_full = (mac_acc + RND12) >>> 12;

  assign half     = op_cnt_r[0];
  assign prod_idx = op_cnt_r[3:1];
  assign s_dig    = half ? {cor_sin[odo_pkg::TRIG_W-1], cor_sin[odo_pkg::TRIG_W-1:odo_pkg::DIG_W]}
                         : {1'b0, cor_sin[odo_pkg::DIG_W-1:0]};
  assign c_dig    = half ? {cor_cos[odo_pkg::TRIG_W-1], cor_cos[odo_pkg::TRIG_W-1:odo_pkg::DIG_W]}
                         : {1'b0, cor_cos[odo_pkg::DIG_W-1:0]};
  assign ts_b     = {1'b0, ts_r};
  assign fwd_a    = odo_pkg::MUL_A_W'(fwd_r);
  assign dt_a     = odo_pkg::MUL_A_W'(dt_r);

  always_comb begin
    mac_ctl  = '0;
    mac_a    = '0;
    mac_b    = '0;
    r_nxt    = r_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    mul_last = 1'b0;
    if (state_r == ST_MUL) begin
      if (!mode_r) begin
        // Each product: low digit clears, high digit accumulates at 2^16.
        // The previous product is consumed on the next low pass.
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = !half;
        mac_ctl.hi    = half;
        case (prod_idx)
          PR0_FS: begin
            mac_a = fwd_a;
            mac_b = s_dig;
          end
          PR0_DC: begin
            mac_a = dt_a;
            mac_b = c_dig;
            if (!half) begin
              dx_nxt = odo_pkg::DELTA_W'(rq_full);
            end
          end
          PR0_FC: begin
            mac_a = fwd_a;
            mac_b = c_dig;
            if (!half) begin
              dx_nxt = dx_r + odo_pkg::DELTA_W'(rq_full);
            end
          end
          PR0_DS: begin
            mac_a = dt_a;
            mac_b = s_dig;
            if (!half) begin
              dy_nxt = odo_pkg::DELTA_W'(rq_full);
            end
          end
          PR0_END: begin
            mac_ctl  = '0;
            dy_nxt   = dy_r - odo_pkg::DELTA_W'(rq_full);
            mul_last = 1'b1;
          end
          default: begin
            mac_ctl  = '0;
            mul_last = 1'b1;
          end
        endcase
      end else begin
        case (prod_idx)
          PR1_FS: begin
            mac_ctl.en    = 1'b1;
            mac_ctl.clear = !half;
            mac_ctl.hi    = half;
            mac_a         = fwd_a;
            mac_b         = s_dig;
          end
          PR1_FC: begin
            mac_ctl.en    = 1'b1;
            mac_ctl.clear = !half;
            mac_ctl.hi    = half;
            mac_a         = fwd_a;
            mac_b         = c_dig;
            if (!half) begin
              r_nxt = odo_pkg::MUL_A_W'(rq_full);
            end
          end
          PR1_TS: begin
            // Single pass each: X first, then Y while X is consumed.
            mac_ctl.en    = 1'b1;
            mac_ctl.clear = 1'b1;
            mac_a         = r_r;
            mac_b         = ts_b;
            if (!half) begin
              r_nxt = odo_pkg::MUL_A_W'(rq_full);
            end else begin
              dx_nxt = odo_pkg::DELTA_W'(r12_full);
            end
          end
          PR1_END: begin
            dy_nxt   = odo_pkg::DELTA_W'(r12_full);
            mul_last = 1'b1;
          end
          default: begin
            mul_last = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cor_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= 1'b0;
      op_cnt_r     <= '0;
      last_left_r  <= '0;
      last_right_r <= '0;
      last_track_r <= '0;
      x_acc_r      <= '0;
      y_acc_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (state_r == ST_MUL) begin
        op_cnt_r <= op_cnt_r + 4'd1;
      end else begin
        op_cnt_r <= '0;
      end
      if (in_xfer) begin
        last_left_r  <= in_left_wheel;
        last_right_r <= in_right_wheel;
        last_track_r <= in_tracking_wheel;
      end
      if (state_r == ST_SAT) begin
        x_acc_r <= sat_add(x_acc_r, dx_r);
        y_acc_r <= sat_add(y_acc_r, dy_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_r <= odo_pkg::DIFF_W'(dsum >>> 1);
      dt_r  <= dt;
      ts_r  <= in_time_step;
    end
    r_r  <= r_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  assign x_ext          = EW'(x_acc_r);
  assign y_ext          = EW'(y_acc_r);
  assign out_x_position = x_ext[odo_pkg::OUT_W-1:0];
  assign out_y_position = y_ext[odo_pkg::OUT_W-1:0];

  `ODO_ASSERT(a_no_accept_with_result, out_valid |-> in_stall, "input taken while result pending")
  `ODO_ASSERT(a_accept_starts_cordic, in_xfer |=> (state_r == ST_CORDIC), "transfer did not start CORDIC")
  `ODO_ASSERT(a_cordic_done_in_phase, cor_done |-> (state_r == ST_CORDIC), "CORDIC finished outside its phase")
  `ODO_ASSERT(a_mac_only_in_mul, mac_ctl.en |-> (state_r == ST_MUL), "multiplier active outside multiply phase")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wheel odometry pose update core. A driver
// feeds wheel samples from a pending queue, and a built-in pose predictor
// (CORDIC sin/cos, rounding, saturating X/Y position) computes each
// expected position. A monitor compares every result transfer against the
// oldest prediction. Both sides idle and stall at random. The mode register
// changes only between phases, once the core is drained.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS   = 16;
  localparam int POSITION_BITS  = 48;
  localparam int ROT_ITERS      = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AT     = 150;
  localparam int STEADY_FROM    = 500;
  localparam int STEADY_TO      = 800;
  localparam int DRAIN_CYCLES   = 2 * (ROT_ITERS + 14);
  localparam int SAT_ITEMS      = 100;

  localparam longint POS_HI = (64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1;
  localparam longint POS_LO = -POS_HI - 64'sd1;
  localparam longint CORDIC_GAIN_Q30 = 64'sh26DD3B6A;

  localparam logic signed [31:0] WHEEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WHEEL_MIN = 32'sh8000_0000;

  typedef enum logic {
    MODE_TRACKING = 1'b0,
    MODE_VELOCITY = 1'b1
  } odo_mode_t;

  typedef struct packed {
    logic signed [odo_pkg::WHEEL_W-1:0] left;
    logic signed [odo_pkg::WHEEL_W-1:0] right;
    logic signed [odo_pkg::WHEEL_W-1:0] track;
    logic [odo_pkg::ANG_W-1:0]          heading;
    logic [odo_pkg::TS_W-1:0]           tstep;
  } wheel_sample_t;

  typedef struct packed {
    logic [odo_pkg::OUT_W-1:0] x;
    logic [odo_pkg::OUT_W-1:0] y;
  } pose_t;

  // atan(2^-i), 2^32 units per turn
  localparam longint ATAN_TURNS [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [odo_pkg::WHEEL_W-1:0] in_left_wheel = '0;
  logic signed [odo_pkg::WHEEL_W-1:0] in_right_wheel = '0;
  logic signed [odo_pkg::WHEEL_W-1:0] in_tracking_wheel = '0;
  logic [odo_pkg::ANG_W-1:0] in_heading = '0;
  logic [odo_pkg::TS_W-1:0] in_time_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [odo_pkg::OUT_W-1:0] out_x_position;
  logic signed [odo_pkg::OUT_W-1:0] out_y_position;

  wheel_sample_t pending_samples[$];
  pose_t         pose_expected[$];
  wheel_sample_t offered;
  pose_t         predicted;
  pose_t         arrived;
  odo_mode_t     mode_cfg = MODE_TRACKING;

  // predictor state, matches the core after reset
  longint prev_left = 0;
  longint prev_right = 0;
  longint prev_track = 0;
  longint x_pos = 0;
  longint y_pos = 0;

  // last wheel readings queued, used to build plausible increments
  logic signed [31:0] plan_left = '0;
  logic signed [31:0] plan_right = '0;
  logic signed [31:0] plan_track = '0;

  int samples_taken = 0;
  int results_seen = 0;
  int holdoff_left = 0;
  int stuck_cycles = 0;
  int mismatches = 0;

  wheel_odometry_pose_update_core #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .POSITION_BITS(POSITION_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_left_wheel    (in_left_wheel),
    .in_right_wheel   (in_right_wheel),
    .in_tracking_wheel(in_tracking_wheel),
    .in_heading       (in_heading),
    .in_time_step     (in_time_step),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x_position   (out_x_position),
    .out_y_position   (out_y_position)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint q30_round(input longint prod);
    return (prod + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint sat_add(input longint acc, input longint d);
    longint sum;
    sum = acc + d;
    if (sum > POS_HI) return POS_HI;
    if (sum < POS_LO) return POS_LO;
    return sum;
  endfunction

  // Compute the position after one sample and advance the predictor state.
  function automatic pose_t advance_pose(input wheel_sample_t s);
    longint lw, rw, tw, dl, dr, dt, fwd;
    longint cx, cy, cz, nx, sn, cs, dx, dy;
    logic [31:0] ang;
    bit flip;
    pose_t p;
    lw = longint'(s.left);
    rw = longint'(s.right);
    tw = longint'(s.track);
    dl = lw - prev_left;
    dr = rw - prev_right;
    dt = tw - prev_track;
    fwd = (dl + dr) >>> 1;

    // fold into [-90, 90) degrees, negate both results on the way out
    ang = {s.heading, 16'h0000};
    flip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
    if (flip) ang = ang - 32'h8000_0000;
    cz = longint'(signed'(ang));
    cx = CORDIC_GAIN_Q30;
    cy = 0;
    for (int i = 0; i < ROT_ITERS; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz = cz - ATAN_TURNS[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz = cz + ATAN_TURNS[i];
      end
      cx = nx;
    end
    sn = flip ? -cy : cy;
    cs = flip ? -cx : cx;

    if (mode_cfg == MODE_TRACKING) begin
      dx = q30_round(fwd * sn) + q30_round(dt * cs);
      dy = q30_round(fwd * cs) - q30_round(dt * sn);
    end else begin
      dx = (q30_round(fwd * sn) * longint'(s.tstep) + 64'sd2048) >>> 12;
      dy = (q30_round(fwd * cs) * longint'(s.tstep) + 64'sd2048) >>> 12;
    end

    prev_left = lw;
    prev_right = rw;
    prev_track = tw;
    x_pos = sat_add(x_pos, dx);
    y_pos = sat_add(y_pos, dy);
    p.x = x_pos[odo_pkg::OUT_W-1:0];
    p.y = y_pos[odo_pkg::OUT_W-1:0];
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic queue_sample(input logic signed [31:0] l, input logic signed [31:0] r,
                              input logic signed [31:0] t, input logic [15:0] h,
                              input logic [15:0] ts);
    wheel_sample_t s;
    s.left = l;
    s.right = r;
    s.track = t;
    s.heading = h;
    s.tstep = ts;
    plan_left = l;
    plan_right = r;
    plan_track = t;
    pending_samples.push_back(s);
  endtask

  // Mostly small increments on the last readings, now and then arbitrary jumps.
  task automatic queue_random();
    logic signed [31:0] l, r, t;
    logic [15:0] h, ts;
    if ($urandom_range(99) < 75) begin
      l = plan_left + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      r = plan_right + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      t = plan_track + $urandom_range(32'h0001_0000) - 32'h0000_8000;
    end else begin
      l = $urandom;
      r = $urandom;
      t = $urandom;
    end
    h = 16'($urandom);
    ts = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h0800));
    queue_sample(l, r, t, h, ts);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || pose_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_mode(input odo_mode_t m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_cfg = m;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = advance_pose(offered);
        pose_expected.push_back(predicted);
        samples_taken++;
      end
      // hold the payload while stalled
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 &&
            ((samples_taken >= STEADY_FROM && samples_taken < STEADY_TO) ||
             $urandom_range(99) >= 34)) begin
          offered = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_left_wheel <= offered.left;
          in_right_wheel <= offered.right;
          in_tracking_wheel <= offered.track;
          in_heading <= offered.heading;
          in_time_step <= offered.tstep;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pose_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%h y=%h",
                                    out_x_position, out_y_position));
        end else begin
          arrived = pose_expected.pop_front();
          if (out_x_position !== arrived.x)
            report_mismatch($sformatf("result %0d x_position got %h want %h",
                                      results_seen, out_x_position, arrived.x));
          if (out_y_position !== arrived.y)
            report_mismatch($sformatf("result %0d y_position got %h want %h",
                                      results_seen, out_y_position, arrived.y));
        end
        results_seen++;
        if (results_seen == HOLDOFF_AT) holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else begin
        out_stall <= !(results_seen >= STEADY_FROM && results_seen < STEADY_TO) &&
                     ($urandom_range(99) < 34);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    bit to_max;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // tracking mode, reset value of the register
    queue_sample(32'sh0, 32'sh0, 32'sh0, 16'h0000, 16'h0000);
    queue_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0, 16'h0000, 16'h1000);
    queue_sample(32'sh0003_0000, 32'sh0003_0000, 32'sh0, 16'h4000, 16'h0000);
    queue_sample(32'sh0003_0000, 32'sh0003_0000, 32'sh0001_0000, 16'h8000, 16'hFFFF);
    queue_sample(32'sh0004_0000, 32'sh0002_0000, 32'sh0001_8000, 16'hC000, 16'h0000);
    queue_sample(32'sh0004_1234, 32'sh0002_4321, 32'sh0001_0000, 16'h3FFF, 16'h0000);
    queue_sample(32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000, 16'hBFFF, 16'h0000);
    queue_sample(WHEEL_MAX, WHEEL_MAX, WHEEL_MIN, 16'hFFFF, 16'h0000);
    queue_sample(WHEEL_MIN, WHEEL_MIN, WHEEL_MAX, 16'h2000, 16'h0000);
    queue_sample(WHEEL_MAX, WHEEL_MIN, WHEEL_MIN, 16'h6000, 16'h0000);
    wait_drained();

    // velocity mode: time step extremes, tracking wheel still refreshed
    write_mode(MODE_VELOCITY);
    queue_sample(32'sh0, 32'sh0, 32'sh0, 16'h0000, 16'h1000);
    queue_sample(32'sh0002_0000, 32'sh0002_0000, 32'sh0005_0000, 16'h0000, 16'h1000);
    queue_sample(32'sh0004_0000, 32'sh0004_0000, 32'sh0007_0000, 16'h4000, 16'h0000);
    queue_sample(32'sh0006_0000, 32'sh0005_0000, 32'sh0009_0000, 16'hA000, 16'hFFFF);
    queue_sample(WHEEL_MAX, WHEEL_MAX, WHEEL_MAX, 16'h8000, 16'hFFFF);
    queue_sample(WHEEL_MIN, WHEEL_MIN, WHEEL_MIN, 16'hE000, 16'hFFFF);
    queue_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh000B_0000, 16'hFFFF, 16'h0001);
    wait_drained();

    // back to tracking: deltas start from the readings kept in velocity mode
    write_mode(MODE_TRACKING);
    queue_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh000B_0000, 16'h1234, 16'h0000);
    queue_sample(32'sh0002_0000, 32'sh0001_8000, 32'sh000A_0000, 16'h5678, 16'h0000);
    repeat (300) queue_random();
    wait_drained();

    write_mode(MODE_VELOCITY);
    repeat (300) queue_random();
    wait_drained();

    write_mode(MODE_TRACKING);
    repeat (150) queue_random();
    wait_drained();

    // Push X up and Y down fast: full-range wheel swings, heading flipped
    // with the sign of the travel, longest time step; the last few reverse.
    write_mode(MODE_VELOCITY);
    write_mode(MODE_VELOCITY);
    to_max = 1'b1;
    for (int k = 0; k < SAT_ITEMS + 20; k++) begin
      if (k < SAT_ITEMS)
        queue_sample(to_max ? WHEEL_MAX : WHEEL_MIN, to_max ? WHEEL_MAX : WHEEL_MIN,
                     32'($urandom_range(16'hFFFF)), to_max ? 16'h6000 : 16'hE000,
                     16'hFFFF);
      else
        queue_sample(to_max ? WHEEL_MAX : WHEEL_MIN, to_max ? WHEEL_MAX : WHEEL_MIN,
                     32'($urandom_range(16'hFFFF)), to_max ? 16'hE000 : 16'h6000,
                     16'hFFFF);
      to_max = !to_max;
    end
    wait_drained();

    write_mode(MODE_TRACKING);
    repeat (150) queue_random();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/odo_pkg.sv
rtl/odo_cordic.sv
rtl/odo_mac.sv
rtl/wheel_odometry_pose_update_core.sv
tb/sv/testbench.sv
